// ===== design/transform_topk_compress_error_unit_defines.svh =====
// Assertion macros shared by the transform top-k error unit.
`ifndef TRANSFORM_TOPK_COMPRESS_ERROR_UNIT_DEFINES_SVH
`define TRANSFORM_TOPK_COMPRESS_ERROR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TTCE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttce check failed");

// Next-cycle implication, checked outside reset.
`define TTCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttce check failed");

`endif

// ===== design/ttce_pkg.sv =====
package ttce_pkg;

    localparam int VAL_W      = 32;
    localparam int WIDE_W     = 48;
    localparam int HALF_W     = 24;
    localparam int PROD_W     = 96;
    localparam int DEV_W      = 32;
    localparam int TOT_W      = 48;
    localparam int CNT_W      = 16;
    localparam int LCFG_W     = 5;
    localparam int POS_W      = 4;
    localparam int ACT_W      = 2;
    localparam int CIDX_W     = 2;
    localparam int CDAT_W     = 16;
    localparam int ROOT_W     = 64;
    localparam int ROOT_STEPS = 32;

    localparam logic [ACT_W-1:0] ACT_ANALYSIS  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SYNTHESIS = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SAMPLE    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR     = 2'd3;

    localparam logic [CIDX_W-1:0] CFG_LENGTH = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_COUNT  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_KEEP   = 2'd2;

    localparam logic [LCFG_W-1:0] LENGTH_RST = 5'd16;
    localparam logic [CNT_W-1:0]  COUNT_RST  = 16'd1;
    localparam logic [LCFG_W-1:0] KEEP_RST   = 5'd2;

    localparam logic signed [WIDE_W-1:0] SAT_POS = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [WIDE_W-1:0] SAT_NEG = 48'sh8000_0000_0000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIM1,
        ST_DIM2,
        ST_RD,
        ST_LD,
        ST_MUL,
        ST_RND,
        ST_ACC,
        ST_ROW,
        ST_ERR,
        ST_SQA,
        ST_TRI,
        ST_TLI,
        ST_TRJ,
        ST_TCJ,
        ST_TDC,
        ST_DIV,
        ST_SQI,
        ST_SQRT,
        ST_FIN
    } t_state;

    typedef enum logic {
        PH_ANA,
        PH_SYN
    } t_phase;

endpackage

// ===== design/transform_topk_compress_error_unit.sv =====
// Transform top-k reconstruction error unit.
// Input channel (i_valid/o_ready) takes one word per action: analysis or synthesis
// matrix entry writes, signal samples and a clear of the running total. Every word
// that does not complete a signal is absorbed while the block stays idle.
// The sample at position signal_length-1 starts the evaluation, with o_ready low
// until it ends. The evaluation uses the one shared 24x24 multiplier, which forms
// every product in four passes, and the bit-serial divide and root.
// The result word (o_valid/i_ready) carries the signal deviation and the saturated
// running total. It sits in an output register, so matrix writes, samples before
// the last and clears are still accepted while it waits; a new evaluation holds in
// its final state until the previous result has been taken.
// Configuration (i_cfg_valid/o_cfg_ready) is always ready, not gated; write it
// only while the block is idle. Reset restores length 16, count 1, keep 2 and clears
// the running total; matrix and sample memories hold nothing defined until written.
module transform_topk_compress_error_unit #(
    parameter int MAX_LENGTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [ttce_pkg::ACT_W-1:0]            i_action,
    input  logic [ttce_pkg::POS_W-1:0]            i_row,
    input  logic [ttce_pkg::POS_W-1:0]            i_column,
    input  logic signed [ttce_pkg::VAL_W-1:0]     i_value,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [ttce_pkg::DEV_W-1:0]            o_signal_deviation,
    output logic [ttce_pkg::TOT_W-1:0]            o_total_deviation,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ttce_pkg::CIDX_W-1:0]           i_cfg_index,
    input  logic [ttce_pkg::CDAT_W-1:0]           i_cfg_data
);

`include "transform_topk_compress_error_unit_defines.svh"

    localparam int IDX_W = $clog2(MAX_LENGTH);
    localparam int LEN_W = $clog2(MAX_LENGTH + 1);
    localparam int W_C   = (LEN_W > ttce_pkg::POS_W) ? LEN_W : ttce_pkg::POS_W;
    localparam int W_L   = (LEN_W > ttce_pkg::LCFG_W) ? LEN_W : ttce_pkg::LCFG_W;
    localparam int ACC_W = ttce_pkg::WIDE_W + LEN_W;
    localparam int SQ_W  = ttce_pkg::PROD_W + LEN_W;
    localparam int DVS_W = 2 * ttce_pkg::CNT_W + LEN_W;
    localparam int K_W   = $clog2(SQ_W);
    localparam int MA_W  = 2 * IDX_W + 1;
    localparam int VA_W  = IDX_W + 1;
    localparam int RND_W = ttce_pkg::PROD_W + 1;
    localparam int CC_W  = 2 * ttce_pkg::CNT_W;

    localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(ttce_pkg::SAT_POS);
    localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(ttce_pkg::SAT_NEG);
    localparam logic [RND_W-1:0] RND_HALF = RND_W'(1) << (FRAC_BITS - 1);
    localparam logic [RND_W-1:0] RND_MAX  = RND_W'(ttce_pkg::SAT_POS);

    ttce_pkg::t_state r_state, n_state;
    ttce_pkg::t_phase r_phase;

    logic [ttce_pkg::LCFG_W-1:0] r_cfg_len, r_cfg_keep;
    logic [ttce_pkg::CNT_W-1:0]  r_cfg_cnt;

    // Matrix memory: analysis entries in the lower half, synthesis in the upper.
    logic signed [ttce_pkg::VAL_W-1:0]  r_mat [2**MA_W];
    logic signed [ttce_pkg::VAL_W-1:0]  r_mat_q;
    logic                               mat_we;
    logic [MA_W-1:0]                    mat_waddr, mat_raddr;
    // Vector memory: samples in the lower half, coefficients in the upper.
    logic signed [ttce_pkg::WIDE_W-1:0] r_vec [2**VA_W];
    logic signed [ttce_pkg::WIDE_W-1:0] r_vec_q, vec_wdata;
    logic                               vec_we;
    logic [VA_W-1:0]                    vec_waddr, vec_raddr;

    logic [IDX_W-1:0]                   r_i, r_j;
    logic signed [ACC_W-1:0]            r_acc;
    logic signed [ttce_pkg::WIDE_W-1:0] r_term;
    logic [ttce_pkg::WIDE_W-1:0]        r_mx, r_my, r_magi;
    logic                               r_neg, r_err;
    logic [1:0]                         r_ms;
    logic [ttce_pkg::PROD_W-1:0]        r_prod;
    logic [SQ_W-1:0]                    r_sq, r_dnum;
    logic [LEN_W-1:0]                   r_larger;
    logic [MAX_LENGTH-1:0]              r_drop;
    logic [2*ttce_pkg::CNT_W-1:0]       r_cc;
    logic [DVS_W-1:0]                   r_dvs, r_rem;
    logic [ttce_pkg::ROOT_W-1:0]        r_q, r_sn, r_res, r_bit;
    logic                               r_qovf;
    logic [K_W-1:0]                     r_k;
    logic [ttce_pkg::TOT_W-1:0]         r_total;
    logic                               r_o_valid;
    logic [ttce_pkg::DEV_W-1:0]         r_o_sig;
    logic [ttce_pkg::TOT_W-1:0]         r_o_tot;

    logic                               in_acc, out_free;
    logic [W_L-1:0]                     cfg_len_x;
    logic [LEN_W-1:0]                   len, len_m1;
    logic [ttce_pkg::CNT_W-1:0]         cnt_eff;
    logic                               i_last, j_last, k_div_last, k_root_last;
    logic [W_C-1:0]                     col_x, row_x;
    logic [IDX_W-1:0]                   col_idx, row_idx;
    logic                               ent_ok, samp_ok, samp_last;
    logic signed [ttce_pkg::WIDE_W-1:0] acc_sat, vb;
    logic [ttce_pkg::VAL_W-1:0]         amag;
    logic [ttce_pkg::WIDE_W-1:0]        bmag, vmag;
    logic [ttce_pkg::HALF_W-1:0]        xa, ya;
    logic [2*ttce_pkg::HALF_W-1:0]      pp;
    logic [ttce_pkg::PROD_W-1:0]        pp_sh;
    logic [RND_W-1:0]                   rnd, rq;
    logic [ttce_pkg::WIDE_W-1:0]        rmag;
    logic signed [ttce_pkg::WIDE_W:0]   diff;
    logic [ttce_pkg::WIDE_W:0]          emag;
    logic [SQ_W-1:0]                    sq_next;
    logic [DVS_W:0]                     rem_sh;
    logic                               rem_ge;
    logic [ttce_pkg::ROOT_W-1:0]        root_t;
    logic                               root_ge;
    logic [ttce_pkg::DEV_W-1:0]         dev;
    logic [ttce_pkg::TOT_W:0]           tot_sum;

    // Effective configuration.
    always_comb begin
        cfg_len_x = W_L'(r_cfg_len);
        if (cfg_len_x == '0) begin
            len = LEN_W'(1);
        end else if (cfg_len_x > W_L'(MAX_LENGTH)) begin
            len = LEN_W'(MAX_LENGTH);
        end else begin
            len = cfg_len_x[LEN_W-1:0];
        end
        len_m1  = len - LEN_W'(1);
        cnt_eff = (r_cfg_cnt == '0) ? ttce_pkg::CNT_W'(1) : r_cfg_cnt;
    end

    assign i_last      = (LEN_W'(r_i) == len_m1);
    assign j_last      = (LEN_W'(r_j) == len_m1);
    assign k_div_last  = (r_k == K_W'(SQ_W - 1));
    assign k_root_last = (r_k == K_W'(ttce_pkg::ROOT_STEPS - 1));

    assign col_x     = W_C'(i_column);
    assign row_x     = W_C'(i_row);
    assign col_idx   = col_x[IDX_W-1:0];
    assign row_idx   = row_x[IDX_W-1:0];
    assign ent_ok    = (row_x < W_C'(MAX_LENGTH)) && (col_x < W_C'(MAX_LENGTH));
    assign samp_ok   = col_x < W_C'(len);
    assign samp_last = col_x == W_C'(len_m1);

    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;

    // Datapath arithmetic.
    always_comb begin
        if (r_acc > ACC_HI) begin
            acc_sat = ttce_pkg::SAT_POS;
        end else if (r_acc < ACC_LO) begin
            acc_sat = ttce_pkg::SAT_NEG;
        end else begin
            acc_sat = r_acc[ttce_pkg::WIDE_W-1:0];
        end

        amag = r_mat_q[ttce_pkg::VAL_W-1] ? (~r_mat_q + 1'b1) : r_mat_q;
        vb   = ((r_phase == ttce_pkg::PH_SYN) && r_drop[r_j]) ? '0 : r_vec_q;
        bmag = vb[ttce_pkg::WIDE_W-1] ? (~vb + 1'b1) : vb;
        vmag = r_vec_q[ttce_pkg::WIDE_W-1] ? (~r_vec_q + 1'b1) : r_vec_q;

        xa = r_ms[0] ? r_mx[2*ttce_pkg::HALF_W-1:ttce_pkg::HALF_W]
                     : r_mx[ttce_pkg::HALF_W-1:0];
        ya = r_ms[1] ? r_my[2*ttce_pkg::HALF_W-1:ttce_pkg::HALF_W]
                     : r_my[ttce_pkg::HALF_W-1:0];
        pp = xa * ya;
        case (r_ms)
            2'd0:    pp_sh = ttce_pkg::PROD_W'(pp);
            2'd3:    pp_sh = ttce_pkg::PROD_W'(pp) << (2 * ttce_pkg::HALF_W);
            default: pp_sh = ttce_pkg::PROD_W'(pp) << ttce_pkg::HALF_W;
        endcase

        // Round half away from zero on the magnitude, then saturate.
        rnd  = RND_W'(r_prod) + RND_HALF;
        rq   = rnd >> FRAC_BITS;
        rmag = (rq > RND_MAX) ? ttce_pkg::SAT_POS : rq[ttce_pkg::WIDE_W-1:0];

        diff = (ttce_pkg::WIDE_W+1)'(r_vec_q) - (ttce_pkg::WIDE_W+1)'(acc_sat);
        emag = diff[ttce_pkg::WIDE_W] ? (~diff + 1'b1) : diff;

        sq_next = r_sq + SQ_W'(r_prod);

        rem_sh = {r_rem, r_dnum[SQ_W-1]};
        rem_ge = rem_sh >= {1'b0, r_dvs};

        root_t  = r_res + r_bit;
        root_ge = r_sn >= root_t;

        dev     = r_qovf ? '1 : r_res[ttce_pkg::DEV_W-1:0];
        tot_sum = {1'b0, r_total} + (ttce_pkg::TOT_W+1)'(dev);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ttce_pkg::ST_IDLE: begin
                if (in_acc && (i_action == ttce_pkg::ACT_SAMPLE) && samp_ok && samp_last) begin
                    n_state = ttce_pkg::ST_DIM1;
                end
            end
            ttce_pkg::ST_DIM1: n_state = ttce_pkg::ST_DIM2;
            ttce_pkg::ST_DIM2: n_state = ttce_pkg::ST_RD;
            ttce_pkg::ST_RD:   n_state = ttce_pkg::ST_LD;
            ttce_pkg::ST_LD:   n_state = ttce_pkg::ST_MUL;
            ttce_pkg::ST_MUL: begin
                if (r_ms == 2'd3) begin
                    n_state = r_err ? ttce_pkg::ST_SQA : ttce_pkg::ST_RND;
                end
            end
            ttce_pkg::ST_RND: n_state = ttce_pkg::ST_ACC;
            ttce_pkg::ST_ACC: n_state = j_last ? ttce_pkg::ST_ROW : ttce_pkg::ST_RD;
            ttce_pkg::ST_ROW: begin
                if (r_phase == ttce_pkg::PH_SYN) begin
                    n_state = ttce_pkg::ST_ERR;
                end else begin
                    n_state = i_last ? ttce_pkg::ST_TRI : ttce_pkg::ST_RD;
                end
            end
            ttce_pkg::ST_ERR: n_state = ttce_pkg::ST_MUL;
            ttce_pkg::ST_SQA: n_state = i_last ? ttce_pkg::ST_DIV : ttce_pkg::ST_RD;
            ttce_pkg::ST_TRI: n_state = ttce_pkg::ST_TLI;
            ttce_pkg::ST_TLI: n_state = ttce_pkg::ST_TRJ;
            ttce_pkg::ST_TRJ: n_state = ttce_pkg::ST_TCJ;
            ttce_pkg::ST_TCJ: n_state = j_last ? ttce_pkg::ST_TDC : ttce_pkg::ST_TRJ;
            ttce_pkg::ST_TDC: n_state = i_last ? ttce_pkg::ST_RD : ttce_pkg::ST_TRI;
            ttce_pkg::ST_DIV: n_state = k_div_last ? ttce_pkg::ST_SQI : ttce_pkg::ST_DIV;
            ttce_pkg::ST_SQI: n_state = r_qovf ? ttce_pkg::ST_FIN : ttce_pkg::ST_SQRT;
            ttce_pkg::ST_SQRT: n_state = k_root_last ? ttce_pkg::ST_FIN : ttce_pkg::ST_SQRT;
            ttce_pkg::ST_FIN:  n_state = out_free ? ttce_pkg::ST_IDLE : ttce_pkg::ST_FIN;
            default:           n_state = ttce_pkg::ST_IDLE;
        endcase
    end

    // Handshake and memory port control.
    always_comb begin
        o_ready     = (r_state == ttce_pkg::ST_IDLE);
        o_cfg_ready = 1'b1;

        mat_we    = in_acc && ent_ok && ((i_action == ttce_pkg::ACT_ANALYSIS) ||
                                         (i_action == ttce_pkg::ACT_SYNTHESIS));
        mat_waddr = {(i_action == ttce_pkg::ACT_SYNTHESIS), row_idx, col_idx};
        mat_raddr = {(r_phase == ttce_pkg::PH_SYN), r_i, r_j};

        vec_we    = 1'b0;
        vec_waddr = {1'b0, col_idx};
        vec_wdata = ttce_pkg::WIDE_W'(i_value);
        if (r_state == ttce_pkg::ST_IDLE) begin
            vec_we = in_acc && (i_action == ttce_pkg::ACT_SAMPLE) && samp_ok;
        end else if ((r_state == ttce_pkg::ST_ROW) && (r_phase == ttce_pkg::PH_ANA)) begin
            vec_we    = 1'b1;
            vec_waddr = {1'b1, r_i};
            vec_wdata = acc_sat;
        end

        case (r_state)
            ttce_pkg::ST_RD:  vec_raddr = {(r_phase == ttce_pkg::PH_SYN), r_j};
            ttce_pkg::ST_ROW: vec_raddr = {1'b0, r_i};
            ttce_pkg::ST_TRI: vec_raddr = {1'b1, r_i};
            ttce_pkg::ST_TRJ: vec_raddr = {1'b1, r_j};
            default:          vec_raddr = {1'b0, r_j};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mat_we) begin
            r_mat[mat_waddr] <= i_value;
        end
        r_mat_q <= r_mat[mat_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (vec_we) begin
            r_vec[vec_waddr] <= vec_wdata;
        end
        r_vec_q <= r_vec[vec_raddr];
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len  <= ttce_pkg::LENGTH_RST;
            r_cfg_cnt  <= ttce_pkg::COUNT_RST;
            r_cfg_keep <= ttce_pkg::KEEP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ttce_pkg::CFG_LENGTH: r_cfg_len  <= i_cfg_data[ttce_pkg::LCFG_W-1:0];
                ttce_pkg::CFG_COUNT:  r_cfg_cnt  <= i_cfg_data;
                ttce_pkg::CFG_KEEP:   r_cfg_keep <= i_cfg_data[ttce_pkg::LCFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ttce_pkg::ST_IDLE;
            r_total   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (in_acc && (i_action == ttce_pkg::ACT_CLEAR)) begin
                r_total <= '0;
            end
            if ((r_state == ttce_pkg::ST_FIN) && out_free) begin
                r_o_valid <= 1'b1;
                r_total   <= tot_sum[ttce_pkg::TOT_W] ? '1 : tot_sum[ttce_pkg::TOT_W-1:0];
            end
        end
    end

    // Evaluation datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ttce_pkg::ST_IDLE: begin
                r_phase <= ttce_pkg::PH_ANA;
                r_i     <= '0;
                r_j     <= '0;
                r_acc   <= '0;
                r_err   <= 1'b0;
            end
            ttce_pkg::ST_DIM1: r_cc  <= CC_W'(cnt_eff) * CC_W'(cnt_eff);
            ttce_pkg::ST_DIM2: r_dvs <= DVS_W'(r_cc) * DVS_W'(len);
            ttce_pkg::ST_LD: begin
                r_mx   <= ttce_pkg::WIDE_W'(amag);
                r_my   <= bmag;
                r_neg  <= r_mat_q[ttce_pkg::VAL_W-1] ^ vb[ttce_pkg::WIDE_W-1];
                r_prod <= '0;
                r_ms   <= '0;
            end
            ttce_pkg::ST_MUL: begin
                r_prod <= r_prod + pp_sh;
                r_ms   <= r_ms + 2'd1;
            end
            ttce_pkg::ST_RND: r_term <= r_neg ? -$signed(rmag) : $signed(rmag);
            ttce_pkg::ST_ACC: begin
                r_acc <= r_acc + ACC_W'(r_term);
                if (!j_last) begin
                    r_j <= r_j + 1'b1;
                end
            end
            ttce_pkg::ST_ROW: begin
                if (r_phase == ttce_pkg::PH_ANA) begin
                    r_i   <= i_last ? '0 : r_i + 1'b1;
                    r_j   <= '0;
                    r_acc <= '0;
                end
            end
            ttce_pkg::ST_ERR: begin
                r_mx   <= emag[ttce_pkg::WIDE_W-1:0];
                r_my   <= emag[ttce_pkg::WIDE_W-1:0];
                r_prod <= '0;
                r_ms   <= '0;
                r_err  <= 1'b1;
            end
            ttce_pkg::ST_SQA: begin
                r_sq  <= sq_next;
                r_err <= 1'b0;
                r_i   <= r_i + 1'b1;
                r_j   <= '0;
                r_acc <= '0;
                r_dnum <= sq_next;
                r_rem  <= '0;
                r_q    <= '0;
                r_qovf <= 1'b0;
                r_k    <= '0;
            end
            ttce_pkg::ST_TLI: begin
                r_magi   <= vmag;
                r_larger <= '0;
                r_j      <= '0;
            end
            ttce_pkg::ST_TCJ: begin
                if (vmag > r_magi) begin
                    r_larger <= r_larger + 1'b1;
                end
                if (!j_last) begin
                    r_j <= r_j + 1'b1;
                end
            end
            ttce_pkg::ST_TDC: begin
                r_drop[r_i] <= W_L'(r_larger) >= W_L'(r_cfg_keep);
                r_i         <= i_last ? '0 : r_i + 1'b1;
                r_j         <= '0;
                r_acc       <= '0;
                r_sq        <= '0;
                if (i_last) begin
                    r_phase <= ttce_pkg::PH_SYN;
                end
            end
            ttce_pkg::ST_DIV: begin
                r_rem  <= rem_ge ? DVS_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[DVS_W-1:0];
                r_dnum <= r_dnum << 1;
                r_q    <= {r_q[ttce_pkg::ROOT_W-2:0], rem_ge};
                r_qovf <= r_qovf | r_q[ttce_pkg::ROOT_W-1];
                r_k    <= r_k + 1'b1;
            end
            ttce_pkg::ST_SQI: begin
                r_sn  <= r_q;
                r_res <= '0;
                r_bit <= ttce_pkg::ROOT_W'(1) << (ttce_pkg::ROOT_W - 2);
                r_k   <= '0;
            end
            ttce_pkg::ST_SQRT: begin
                if (root_ge) begin
                    r_sn  <= r_sn - root_t;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_k   <= r_k + 1'b1;
            end
            ttce_pkg::ST_FIN: begin
                if (out_free) begin
                    r_o_sig <= dev;
                    r_o_tot <= tot_sum[ttce_pkg::TOT_W] ? '1 : tot_sum[ttce_pkg::TOT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_valid            = r_o_valid;
    assign o_signal_deviation = r_o_sig;
    assign o_total_deviation  = r_o_tot;

    `TTCE_ASSERT_NOW(a_result_from_fin, i_clk, i_rst_n, $rose(r_o_valid), $past(r_state) == ttce_pkg::ST_FIN)
    `TTCE_ASSERT_NOW(a_root_fits, i_clk, i_rst_n, (r_state == ttce_pkg::ST_FIN) && !r_qovf, r_res[ttce_pkg::ROOT_W-1:ttce_pkg::DEV_W] == '0)
    `TTCE_ASSERT_NOW(a_total_drops_on_clear, i_clk, i_rst_n, r_total < $past(r_total), $past(in_acc && (i_action == ttce_pkg::ACT_CLEAR)))
    `TTCE_ASSERT_NEXT(a_busy_blocks_input, i_clk, i_rst_n, r_state == ttce_pkg::ST_DIM1, !o_ready)

endmodule
